FILE: rtl/cbbr_pkg.sv
package cbbr_pkg;

	localparam int MAX_RADIUS_DEF = 24;
	localparam int RAD_W = 5;
	localparam int CH_W = 8;
	localparam int NCH = 4;
	localparam int PIX_W = NCH * CH_W;
	// window offset counter, covers -31 .. 62
	localparam int T_W = 8;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic signed [T_W-1:0] tidx_t;

	typedef struct packed {
		logic load;
		logic shift;
		pix_t first;
	} tap_ctrl_t;

	typedef struct packed {
		logic  clear;
		logic  add;
		logic  shift;
		tidx_t t;
		tidx_t two_r;
		pix_t  pix;
	} acc_ctrl_t;

	typedef struct packed {
		logic valid;
		logic last;
	} res_tag_t;

endpackage

FILE: rtl/clamped_box_blur_row.sv
// Horizontal RGBA box blur, one pixel word per accept, edge-clamped window of 2r+1.
// Each word is loaded into the snapshot cell chain, swept over its window (from
// offset -r with tlast) and drained one result slot at a time (r+1 slots with tlast);
// s_tready is low until the drain ends. Results pass the cbbr_scale product and output
// registers to m_tdata; output stalls hold the drain.
// arst_n (async, active low) clears control, row position and sets radius to 1;
// pixel storage needs no clearing pass.
module clamped_box_blur_row #(
	parameter int MAX_RADIUS = cbbr_pkg::MAX_RADIUS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [cbbr_pkg::RAD_W-1:0]    cfg_wdata,   // blur_radius
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [cbbr_pkg::PIX_W-1:0]    s_tdata,     // pix_red, pix_green, pix_blue, pix_alpha
	input  logic                          s_tlast,     // row_end
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [cbbr_pkg::PIX_W-1:0]    m_tdata,     // avg_red, avg_green, avg_blue, avg_alpha
	output logic                          m_tlast      // out_row_end
);
	import cbbr_pkg::*;

	localparam int RAD_CAP = (1 << RAD_W) - 1;
	localparam int RMAX = (MAX_RADIUS < RAD_CAP) ? MAX_RADIUS : RAD_CAP;
	localparam int NTAP = 2 * RMAX + 1;
	localparam int NACC = RMAX + 1;
	localparam int POS_CAP = 2 * MAX_RADIUS + 1;
	localparam int POS_W = $clog2(POS_CAP + 1);
	localparam int R_W = $clog2(RMAX + 1);
	localparam int SUM_W = $clog2(NTAP * ((1 << CH_W) - 1) + 1);
	localparam int SHIFT = SUM_W + $clog2(NTAP + 1);
	localparam int M_W = SHIFT - 1;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SWEEP = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t            state_q;
	logic [RAD_W-1:0]  cfg_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  p_item_q;
	logic              end_item_q;
	pix_t              first_q;
	tidx_t             t_q;
	logic [R_W-1:0]    d_q;
	logic [M_W-1:0]    recip_q;

	logic [R_W-1:0]    r_eff;
	logic [R_W-1:0]    d_last;
	tidx_t             r_t;
	tidx_t             two_r;
	tidx_t             t_start;
	pix_t              first_new;
	logic              acc_in;
	logic              sc_ready;
	logic              drain_step;
	logic              reach;
	tap_ctrl_t         tap_ctrl;
	acc_ctrl_t         acc_ctrl;
	res_tag_t          tag;

	logic [M_W-1:0]            recip_tab [0:RMAX];
	pix_t                      hist_w [0:NTAP-1];
	pix_t                      snap_w [0:NTAP];
	logic [NCH-1:0][SUM_W-1:0] sum_w  [0:NACC];

	// reciprocal table, entry 0 never selected
	assign recip_tab[0] = '0;
	for (genvar g = 1; g <= RMAX; g++) begin : g_recip
		localparam int D = 2 * g + 1;
		assign recip_tab[g] = M_W'(((1 << SHIFT) + D - 1) / D);
	end

	always_comb begin
		if (cfg_q == '0) begin
			r_eff = R_W'(1);
		end else if (cfg_q > RAD_W'(RMAX)) begin
			r_eff = R_W'(RMAX);
		end else begin
			r_eff = R_W'(cfg_q);
		end
	end

	assign r_t       = T_W'(r_eff);
	assign two_r     = r_t + r_t;
	assign t_start   = s_tlast ? -r_t : tidx_t'(0);
	assign first_new = (pos_q == '0) ? s_tdata : first_q;
	assign s_tready  = state_q == ST_IDLE;
	assign acc_in    = s_tvalid && s_tready;

	assign drain_step = (state_q == ST_DRAIN) && sc_ready;
	assign d_last     = end_item_q ? r_eff : '0;
	// slot d holds the window centered r-d words back; it exists once d+p >= r
	assign reach      = ((POS_W+1)'(d_q) + (POS_W+1)'(p_item_q)) >= (POS_W+1)'(r_eff);
	assign tag.valid  = drain_step && ((d_q == '0) || end_item_q) && reach;
	assign tag.last   = end_item_q && (d_q == r_eff);

	assign tap_ctrl.load  = acc_in;
	assign tap_ctrl.shift = (state_q == ST_SWEEP) && !t_q[T_W-1];
	assign tap_ctrl.first = first_new;

	assign acc_ctrl.clear = acc_in;
	assign acc_ctrl.add   = state_q == ST_SWEEP;
	assign acc_ctrl.shift = drain_step;
	assign acc_ctrl.t     = t_q;
	assign acc_ctrl.two_r = two_r;
	assign acc_ctrl.pix   = snap_w[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cfg_q   <= RAD_W'(1);
			pos_q   <= '0;
			t_q     <= '0;
			d_q     <= '0;
		end else begin
			if (cfg_wen) begin
				cfg_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc_in) begin
						state_q <= ST_SWEEP;
						t_q     <= t_start;
						if (s_tlast) begin
							pos_q <= '0;
						end else if (pos_q < POS_W'(POS_CAP)) begin
							pos_q <= pos_q + 1'b1;
						end
					end
				end
				ST_SWEEP: begin
					t_q <= t_q + tidx_t'(1);
					if (t_q == two_r) begin
						state_q <= ST_DRAIN;
						d_q     <= '0;
					end
				end
				ST_DRAIN: begin
					if (sc_ready) begin
						if (d_q == d_last) begin
							state_q <= ST_IDLE;
						end else begin
							d_q <= d_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			first_q    <= first_new;
			p_item_q   <= pos_q;
			end_item_q <= s_tlast;
			recip_q    <= recip_tab[r_eff];
		end
	end

	assign hist_w[0]    = s_tdata;
	assign snap_w[NTAP] = '0;
	for (genvar k = 0; k < NTAP; k++) begin : g_tap
		if (k < NTAP - 1) begin : g_mid
			cbbr_tap_cell #(
				.IDX   (k),
				.POS_W (POS_W)
			) u_tap (
				.clk      (clk),
				.ctrl     (tap_ctrl),
				.pos      (pos_q),
				.hist_in  (hist_w[k]),
				.snap_in  (snap_w[k+1]),
				.hist_out (hist_w[k+1]),
				.snap_out (snap_w[k])
			);
		end else begin : g_end
			cbbr_tap_cell #(
				.IDX   (k),
				.POS_W (POS_W)
			) u_tap (
				.clk      (clk),
				.ctrl     (tap_ctrl),
				.pos      (pos_q),
				.hist_in  (hist_w[k]),
				.snap_in  (snap_w[k+1]),
				.hist_out (),
				.snap_out (snap_w[k])
			);
		end
	end

	assign sum_w[NACC] = '0;
	for (genvar d = 0; d < NACC; d++) begin : g_acc
		cbbr_acc_cell #(
			.IDX   (d),
			.SUM_W (SUM_W)
		) u_acc (
			.clk     (clk),
			.ctrl    (acc_ctrl),
			.sum_in  (sum_w[d+1]),
			.sum_out (sum_w[d])
		);
	end

	cbbr_scale #(
		.SUM_W (SUM_W),
		.M_W   (M_W),
		.SHIFT (SHIFT)
	) u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.tag      (tag),
		.sums     (sum_w[0]),
		.recip    (recip_q),
		.ready    (sc_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	a_pos_cap: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(POS_CAP))
		else $error("row position beyond cap");

	a_last_clears_pos: assert property (@(posedge clk) disable iff (!arst_n)
		acc_in && s_tlast |=> pos_q == '0)
		else $error("row position not cleared after last word");

	a_drain_starts_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) && ($past(state_q) == ST_SWEEP) |-> d_q == '0)
		else $error("drain does not start at slot zero");

endmodule

FILE: rtl/cbbr_tap_cell.sv
module cbbr_tap_cell #(
	parameter int IDX = 0,
	parameter int POS_W = 6
) (
	input  logic                clk,
	input  cbbr_pkg::tap_ctrl_t ctrl,
	input  logic [POS_W-1:0]    pos,
	input  cbbr_pkg::pix_t      hist_in,
	input  cbbr_pkg::pix_t      snap_in,
	output cbbr_pkg::pix_t      hist_out,
	output cbbr_pkg::pix_t      snap_out
);
	import cbbr_pkg::*;

	pix_t hist_q;
	pix_t snap_q;
	logic in_row;

	// positions beyond the pixels seen in this row clamp to the first pixel
	assign in_row = POS_W'(IDX) <= pos;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			hist_q <= hist_in;
			snap_q <= in_row ? hist_in : ctrl.first;
		end else if (ctrl.shift) begin
			snap_q <= snap_in;
		end
	end

	assign hist_out = hist_q;
	assign snap_out = snap_q;

endmodule

FILE: rtl/cbbr_acc_cell.sv
module cbbr_acc_cell #(
	parameter int IDX = 0,
	parameter int SUM_W = 14
) (
	input  logic                                  clk,
	input  cbbr_pkg::acc_ctrl_t                   ctrl,
	input  logic [cbbr_pkg::NCH-1:0][SUM_W-1:0]   sum_in,
	output logic [cbbr_pkg::NCH-1:0][SUM_W-1:0]   sum_out
);
	import cbbr_pkg::*;

	localparam tidx_t LO = T_W'(-IDX);

	tidx_t hi;
	logic  hit;
	logic [NCH-1:0][SUM_W-1:0] sum_q;

	// cell IDX sums offsets -IDX .. 2r-IDX
	assign hi  = ctrl.two_r - T_W'(IDX);
	assign hit = (ctrl.t >= LO) && (ctrl.t <= hi);

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			sum_q <= '0;
		end else if (ctrl.add) begin
			if (hit) begin
				for (int c = 0; c < NCH; c++) begin
					sum_q[c] <= sum_q[c] + SUM_W'(ctrl.pix[c*CH_W +: CH_W]);
				end
			end
		end else if (ctrl.shift) begin
			sum_q <= sum_in;
		end
	end

	assign sum_out = sum_q;

endmodule

FILE: rtl/cbbr_scale.sv
module cbbr_scale #(
	parameter int SUM_W = 14,
	parameter int M_W = 19,
	parameter int SHIFT = 20
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cbbr_pkg::res_tag_t                  tag,
	input  logic [cbbr_pkg::NCH-1:0][SUM_W-1:0] sums,
	input  logic [M_W-1:0]                      recip,
	output logic                                ready,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [cbbr_pkg::PIX_W-1:0]          m_tdata,
	output logic                                m_tlast
);
	import cbbr_pkg::*;

	localparam int P_W = SUM_W + M_W;

	logic en;
	logic vld_s1;
	logic last_s1;
	logic [NCH-1:0][P_W-1:0] prod_s1;
	logic vld_q;
	logic last_q;
	logic [NCH-1:0][CH_W-1:0] avg_q;

	assign en = !vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_q  <= 1'b0;
		end else if (en) begin
			vld_s1 <= tag.valid;
			vld_q  <= vld_s1;
		end
	end

	// floor(sum / (2r+1)) as sum * ceil(2^SHIFT / (2r+1)) >> SHIFT
	always_ff @(posedge clk) begin
		if (en) begin
			last_s1 <= tag.last;
			last_q  <= last_s1;
			for (int c = 0; c < NCH; c++) begin
				prod_s1[c] <= P_W'(sums[c]) * P_W'(recip);
				avg_q[c]   <= prod_s1[c][SHIFT +: CH_W];
			end
		end
	end

	assign ready    = en;
	assign m_tvalid = vld_q;
	assign m_tdata  = avg_q;
	assign m_tlast  = last_q;

endmodule
